// ===== sv/ecg_r_peak_rate_detector_macros.svh =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector assertion macros
// Shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ECG_R_PEAK_RATE_DETECTOR_MACROS_SVH
`define ECG_R_PEAK_RATE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ECGRPD_ASSERT_IMP(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ECGRPD_ASSERT_NXT(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
		else $error("assertion failed");

`else

`define ECGRPD_ASSERT_IMP(lbl, clk, rstn, ant, con)
`define ECGRPD_ASSERT_NXT(lbl, clk, rstn, ant, con)

`endif

`endif

// ===== sv/ecgrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector package
// Widths, register indexes, reset values and controller/datapath interface
// ----------------------------------------------------------------------------
package ecgrpd_pkg;

	// sample and slope width
	localparam int SAMPLE_BITS = 12;
	// distance in samples for the slope difference
	localparam int SLOPE_LAG   = 4;

	localparam int RATE_BITS   = 16;
	localparam int IVAL_BITS   = 16;
	localparam int REFR_BITS   = 8;
	localparam int LIM_BITS    = 15;
	localparam int STEP_BITS   = 8;
	localparam int CFG_BITS    = 16;
	localparam int CFG_ADDR_W  = 3;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RATE_BITS + SAMPLE_BITS + 7) / 8) * 8;

	// divide by three as multiply by reciprocal, exact for SAMPLE_BITS inputs
	localparam int RECIP3_SHIFT = SAMPLE_BITS + 1;
	localparam logic [SAMPLE_BITS-1:0] RECIP3 =
		SAMPLE_BITS'(((1 << RECIP3_SHIFT) + 2) / 3);

	// rate divider, one quotient bit per cycle
	localparam int DIV_STEPS = RATE_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_REFR_LIMIT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IVAL_MIN   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_IVAL_MAX   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_NUM   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_TICK_STEP  = 3'd5;

	// register reset values
	localparam logic [REFR_BITS-1:0] RST_REFR_LIMIT = 8'd60;
	localparam logic [LIM_BITS-1:0]  RST_TIMEOUT    = 15'd1000;
	localparam logic [LIM_BITS-1:0]  RST_IVAL_MIN   = 15'd65;
	localparam logic [LIM_BITS-1:0]  RST_IVAL_MAX   = 15'd500;
	localparam logic [RATE_BITS-1:0] RST_RATE_NUM   = 16'd15000;
	localparam logic [STEP_BITS-1:0] RST_TICK_STEP  = 8'd4;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic calc;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_div;
	} dp_stat_t;

endpackage

// ===== sv/ecgrpd_dp.sv =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector datapath
// Slope, threshold, refractory and interval state, rate divider, output word
// ----------------------------------------------------------------------------
module ecgrpd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ecgrpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [ecgrpd_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic [ecgrpd_pkg::SAMPLE_BITS-1:0]   sample,
	input  ecgrpd_pkg::dp_cmd_t                  cmd,
	output ecgrpd_pkg::dp_stat_t                 stat,
	output logic                                 out_beat,
	output logic [ecgrpd_pkg::RATE_BITS-1:0]     out_rate,
	output logic [ecgrpd_pkg::SAMPLE_BITS-1:0]   out_slope
);

	localparam int SB = ecgrpd_pkg::SAMPLE_BITS;
	localparam int IB = ecgrpd_pkg::IVAL_BITS;
	localparam int RB = ecgrpd_pkg::RATE_BITS;
	localparam int FB = ecgrpd_pkg::REFR_BITS;
	localparam int LB = ecgrpd_pkg::LIM_BITS;
	localparam int TB = ecgrpd_pkg::STEP_BITS;

	// configuration registers
	logic [FB-1:0] refr_limit_q;
	logic [LB-1:0] timeout_q;
	logic [LB-1:0] ival_min_q;
	logic [LB-1:0] ival_max_q;
	logic [RB-1:0] rate_num_q;
	logic [TB-1:0] tick_step_q;

	// detector state
	logic [SB-1:0] win_q [ecgrpd_pkg::SLOPE_LAG];
	logic [SB-1:0] sample_q;
	logic [SB-1:0] max_q;
	logic [SB-1:0] max_prev_q;
	logic [SB-1:0] thr_q;
	logic          armed_q;
	logic [FB-1:0] refr_q;
	logic [IB-1:0] ival_q;
	logic [IB-1:0] last_ival_q;
	logic [RB-1:0] rate_hold_q;

	// per-item results
	logic          res_beat_q;
	logic [SB-1:0] res_slope_q;
	logic          div_used_q;

	// divider
	logic [RB-1:0] rem_q;
	logic [RB-1:0] quo_q;
	logic [RB-1:0] dvs_q;

	// output word
	logic          out_beat_q;
	logic [RB-1:0] out_rate_q;
	logic [SB-1:0] out_slope_q;

	// next-state signals
	logic [SB-1:0]     oldest;
	logic [SB-1:0]     slope;
	logic [SB-1:0]     max1;
	logic              beat;
	logic              armed1;
	logic [IB-1:0]     ival1;
	logic [IB-1:0]     last_ival1;
	logic [FB:0]       refr_next;
	logic              rearm;
	logic [SB:0]       mean_sum;
	logic [SB-1:0]     mean;
	logic [2*SB-1:0]   third_prod;
	logic [SB-1:0]     third;
	logic [SB-1:0]     max2;
	logic [SB-1:0]     prev2;
	logic [SB-1:0]     thr2;
	logic              armed2;
	logic [FB-1:0]     refr2;
	logic              tmo;
	logic [SB-1:0]     max3;
	logic [SB-1:0]     thr3;
	logic              armed3;
	logic [IB-1:0]     ival2;
	logic [IB:0]       ival_sum;
	logic [IB-1:0]     ival3;
	logic              need_div;
	logic [RB:0]       trial;
	logic [RB:0]       diff;

	// per-sample update
	always_comb begin
		oldest = win_q[ecgrpd_pkg::SLOPE_LAG-1];
		slope  = (oldest > sample_q) ? (oldest - sample_q) : (sample_q - oldest);
		max1   = (slope > max_q) ? slope : max_q;

		// beat detection while waiting
		beat       = !armed_q && (slope > thr_q);
		armed1     = armed_q || beat;
		last_ival1 = beat ? ival_q : last_ival_q;
		ival1      = beat ? '0 : ival_q;

		// refractory count and rearm
		refr_next  = {1'b0, refr_q} + (FB+1)'(armed1);
		rearm      = refr_next > {1'b0, refr_limit_q};
		mean_sum   = {1'b0, max1} + {1'b0, max_prev_q};
		mean       = mean_sum[SB:1];
		third_prod = mean * ecgrpd_pkg::RECIP3;
		third      = SB'(third_prod >> ecgrpd_pkg::RECIP3_SHIFT);
		if (rearm) begin
			max2   = '0;
			prev2  = max1;
			thr2   = mean - third;
			armed2 = 1'b0;
			refr2  = '0;
		end else begin
			max2   = max1;
			prev2  = max_prev_q;
			thr2   = thr_q;
			armed2 = armed1;
			refr2  = refr_next[FB-1:0];
		end

		// timeout
		tmo = ival1 > {1'b0, timeout_q};
		if (tmo) begin
			max3   = '0;
			thr3   = '0;
			armed3 = 1'b1;
			ival2  = '0;
		end else begin
			max3   = max2;
			thr3   = thr2;
			armed3 = armed2;
			ival2  = ival1;
		end

		// rate update window
		need_div = (last_ival1 > {1'b0, ival_min_q}) && (last_ival1 < {1'b0, ival_max_q});

		// saturating interval advance
		ival_sum = {1'b0, ival2} + (IB+1)'(tick_step_q);
		ival3    = ival_sum[IB] ? {IB{1'b1}} : ival_sum[IB-1:0];

		// restoring divide step
		trial = {rem_q, quo_q[RB-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	assign stat.need_div = need_div;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_limit_q <= ecgrpd_pkg::RST_REFR_LIMIT;
			timeout_q    <= ecgrpd_pkg::RST_TIMEOUT;
			ival_min_q   <= ecgrpd_pkg::RST_IVAL_MIN;
			ival_max_q   <= ecgrpd_pkg::RST_IVAL_MAX;
			rate_num_q   <= ecgrpd_pkg::RST_RATE_NUM;
			tick_step_q  <= ecgrpd_pkg::RST_TICK_STEP;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ecgrpd_pkg::REG_REFR_LIMIT: refr_limit_q <= cfg_data[FB-1:0];
				ecgrpd_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data[LB-1:0];
				ecgrpd_pkg::REG_IVAL_MIN:   ival_min_q   <= cfg_data[LB-1:0];
				ecgrpd_pkg::REG_IVAL_MAX:   ival_max_q   <= cfg_data[LB-1:0];
				ecgrpd_pkg::REG_RATE_NUM:   rate_num_q   <= cfg_data[RB-1:0];
				ecgrpd_pkg::REG_TICK_STEP:  tick_step_q  <= cfg_data[TB-1:0];
				default: ;
			endcase
		end
	end

	// detector state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ecgrpd_pkg::SLOPE_LAG; i++) begin
				win_q[i] <= '0;
			end
			max_q       <= '0;
			max_prev_q  <= '0;
			thr_q       <= '0;
			armed_q     <= 1'b0;
			refr_q      <= '0;
			ival_q      <= '0;
			last_ival_q <= '0;
			rate_hold_q <= '0;
		end else begin
			if (cmd.calc) begin
				win_q[0] <= sample_q;
				for (int i = 1; i < ecgrpd_pkg::SLOPE_LAG; i++) begin
					win_q[i] <= win_q[i-1];
				end
				max_q       <= max3;
				max_prev_q  <= prev2;
				thr_q       <= thr3;
				armed_q     <= armed3;
				refr_q      <= refr2;
				ival_q      <= ival3;
				last_ival_q <= last_ival1;
			end
			if (cmd.load_out && div_used_q) begin
				rate_hold_q <= quo_q;
			end
		end
	end

	// sample capture, per-item results and divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.calc) begin
			res_beat_q  <= beat;
			res_slope_q <= slope;
			div_used_q  <= need_div;
			rem_q       <= '0;
			quo_q       <= rate_num_q;
			dvs_q       <= last_ival1;
		end else if (cmd.div_step) begin
			if (!diff[RB]) begin
				rem_q <= diff[RB-1:0];
				quo_q <= {quo_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= trial[RB-1:0];
				quo_q <= {quo_q[RB-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			out_beat_q  <= res_beat_q;
			out_rate_q  <= div_used_q ? quo_q : rate_hold_q;
			out_slope_q <= res_slope_q;
		end
	end

	assign out_beat  = out_beat_q;
	assign out_rate  = out_rate_q;
	assign out_slope = out_slope_q;

endmodule

// ===== sv/ecgrpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector controller
// Sequences capture, update, rate division and output word handoff
// ----------------------------------------------------------------------------
`include "ecg_r_peak_rate_detector_macros.svh"

module ecgrpd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ecgrpd_pkg::dp_stat_t  stat,
	output ecgrpd_pkg::dp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CALC = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	logic [ecgrpd_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                              out_valid_q;
	logic                              div_last;
	logic                              out_free;

	assign div_last = cnt_q == ecgrpd_pkg::DIV_CNT_W'(ecgrpd_pkg::DIV_STEPS - 1);
	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.calc     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = stat.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// state, divide counter and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// assertions
	`ECGRPD_ASSERT_NXT(a_accept_to_calc, clk, arst_n, in_valid && in_ready, state_q == S_CALC)
	`ECGRPD_ASSERT_NXT(a_div_ends, clk, arst_n, state_q == S_DIV && div_last, state_q == S_DONE)
	`ECGRPD_ASSERT_NXT(a_load_shows, clk, arst_n, cmd.load_out, out_valid_q)
	`ECGRPD_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)

endmodule

// ===== sv/ecg_r_peak_rate_detector.sv =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector
// Derivative and threshold QRS detector with heart-rate estimate per sample
// ----------------------------------------------------------------------------
// Each accepted sample yields one output word with the beat flag, the held
// heart rate and the four-sample slope. After the accepting edge the sample
// passes the calc state and then the done state when no rate update is due;
// when the latched interval is in range the 16-step restoring divider runs
// between them and forms rate_numerator / interval one quotient bit per cycle.
// The done state registers the output word once the output register is free.
// Samples are taken only in the idle state, so a new sample is taken once the
// previous one has been handed to the output register; the output word may
// still be waiting for the sink at that point.
module ecg_r_peak_rate_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [ecgrpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [ecgrpd_pkg::CFG_BITS-1:0]       cfg_data,
	// sample stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [ecgrpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // sample
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [ecgrpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // heart_rate, slope
	output logic                                  m_axis_tuser   // beat
);

	localparam int SB = ecgrpd_pkg::SAMPLE_BITS;
	localparam int RB = ecgrpd_pkg::RATE_BITS;

	ecgrpd_pkg::dp_cmd_t   cmd;
	ecgrpd_pkg::dp_stat_t  stat;
	logic                  out_beat;
	logic [RB-1:0]         out_rate;
	logic [SB-1:0]         out_slope;

	// sequencing
	ecgrpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// detector datapath
	ecgrpd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.sample    (s_axis_tdata[SB-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.out_beat  (out_beat),
		.out_rate  (out_rate),
		.out_slope (out_slope)
	);

	// output word packing
	assign m_axis_tdata = ecgrpd_pkg::OUT_TDATA_W'({out_slope, out_rate});
	assign m_axis_tuser = out_beat;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// ECG R-peak rate detector testbench
// Streams directed and synthetic ECG samples through the detector under
// several register settings and random source/sink stalls, and checks every
// output word against a cycle-free model of the beat, rate and slope logic
// ----------------------------------------------------------------------------
module tb_top;

	// writes to these indexes land on no register
	localparam logic [ecgrpd_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ecgrpd_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                               beat;
		logic [ecgrpd_pkg::RATE_BITS-1:0]   rate;
		logic [ecgrpd_pkg::SAMPLE_BITS-1:0] slope;
	} beat_word_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [ecgrpd_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [ecgrpd_pkg::CFG_BITS-1:0]    cfg_data = '0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [ecgrpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [ecgrpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                               m_axis_tuser;

	// register copies
	logic [ecgrpd_pkg::REFR_BITS-1:0] refr_limit;
	logic [ecgrpd_pkg::LIM_BITS-1:0]  timeout_lim;
	logic [ecgrpd_pkg::LIM_BITS-1:0]  ival_min;
	logic [ecgrpd_pkg::LIM_BITS-1:0]  ival_max;
	logic [ecgrpd_pkg::RATE_BITS-1:0] rate_num;
	logic [ecgrpd_pkg::STEP_BITS-1:0] tick_step;

	// detector state copies
	logic [ecgrpd_pkg::SAMPLE_BITS-1:0] win [ecgrpd_pkg::SLOPE_LAG];
	logic [ecgrpd_pkg::SAMPLE_BITS-1:0] slope_max;
	logic [ecgrpd_pkg::SAMPLE_BITS-1:0] slope_max_prev;
	logic [ecgrpd_pkg::SAMPLE_BITS-1:0] thresh;
	logic                               armed;
	logic [ecgrpd_pkg::REFR_BITS-1:0]   refr_cnt;
	logic [ecgrpd_pkg::IVAL_BITS-1:0]   ival_cnt;
	logic [ecgrpd_pkg::IVAL_BITS-1:0]   last_ival;
	logic [ecgrpd_pkg::RATE_BITS-1:0]   rate_hold;

	logic [ecgrpd_pkg::SAMPLE_BITS-1:0] ecg_samples [$];
	beat_word_t                         beat_words_due [$];

	int mismatches = 0;
	int accepted = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit in_taken = 1'b0;
	bit sink_hold = 1'b0;
	bit no_idle = 1'b0;

	ecg_r_peak_rate_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// register write seen by the model
	function automatic void apply_reg(input logic [ecgrpd_pkg::CFG_ADDR_W-1:0] a,
		input logic [ecgrpd_pkg::CFG_BITS-1:0] d);
		case (a)
			ecgrpd_pkg::REG_REFR_LIMIT: refr_limit = d[ecgrpd_pkg::REFR_BITS-1:0];
			ecgrpd_pkg::REG_TIMEOUT:    timeout_lim = d[ecgrpd_pkg::LIM_BITS-1:0];
			ecgrpd_pkg::REG_IVAL_MIN:   ival_min = d[ecgrpd_pkg::LIM_BITS-1:0];
			ecgrpd_pkg::REG_IVAL_MAX:   ival_max = d[ecgrpd_pkg::LIM_BITS-1:0];
			ecgrpd_pkg::REG_RATE_NUM:   rate_num = d[ecgrpd_pkg::RATE_BITS-1:0];
			ecgrpd_pkg::REG_TICK_STEP:  tick_step = d[ecgrpd_pkg::STEP_BITS-1:0];
			default: ;
		endcase
	endfunction

	// one sample through slope, beat, refractory, timeout, rate and interval
	function automatic beat_word_t predict_beat_word(
		input logic [ecgrpd_pkg::SAMPLE_BITS-1:0] x);
		beat_word_t w;
		int xs, oldest, diff, nxt, mean, ival;
		xs = x;
		oldest = win[ecgrpd_pkg::SLOPE_LAG-1];
		for (int i = ecgrpd_pkg::SLOPE_LAG - 1; i > 0; i--)
			win[i] = win[i-1];
		win[0] = x;
		diff = (oldest > xs) ? oldest - xs : xs - oldest;
		if (diff > int'(slope_max))
			slope_max = diff[ecgrpd_pkg::SAMPLE_BITS-1:0];
		w.beat = 1'b0;

		// beat while waiting
		if (!armed && diff > int'(thresh)) begin
			armed = 1'b1;
			last_ival = ival_cnt;
			ival_cnt = '0;
			w.beat = 1'b1;
		end

		// refractory count, compared before it is stored
		nxt = int'(refr_cnt) + (armed ? 1 : 0);
		if (nxt > int'(refr_limit)) begin
			mean = (int'(slope_max) + int'(slope_max_prev)) / 2;
			refr_cnt = '0;
			armed = 1'b0;
			thresh = ecgrpd_pkg::SAMPLE_BITS'(mean - mean / 3);
			slope_max_prev = slope_max;
			slope_max = '0;
		end else begin
			refr_cnt = nxt[ecgrpd_pkg::REFR_BITS-1:0];
		end

		// no beat for too long
		if (int'(ival_cnt) > int'(timeout_lim)) begin
			slope_max = '0;
			thresh = '0;
			armed = 1'b1;
			ival_cnt = '0;
		end

		if (int'(last_ival) > int'(ival_min) && int'(last_ival) < int'(ival_max))
			rate_hold = ecgrpd_pkg::RATE_BITS'(int'(rate_num) / int'(last_ival));

		// saturating interval counter
		ival = int'(ival_cnt) + int'(tick_step);
		if (ival > 65535)
			ival = 65535;
		ival_cnt = ival[ecgrpd_pkg::IVAL_BITS-1:0];

		w.rate = rate_hold;
		w.slope = diff[ecgrpd_pkg::SAMPLE_BITS-1:0];
		return w;
	endfunction

	// sample source
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			in_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(0, 12);
				s_axis_tvalid <= 1'b0;
			end else if (ecg_samples.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= ecgrpd_pkg::IN_TDATA_W'(ecg_samples[0]);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// accepted sample goes through the model
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			beat_words_due.push_back(
				predict_beat_word(s_axis_tdata[ecgrpd_pkg::SAMPLE_BITS-1:0]));
			void'(ecg_samples.pop_front());
			in_taken = 1'b1;
			accepted++;
		end
	end

	// result sink with random stalls and the long hold-off
	always @(negedge clk) begin
		if (sink_hold) begin
			m_axis_tready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			m_axis_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			out_gap = $urandom_range(0, 12);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each output word with the oldest prediction
	always @(posedge clk) begin
		beat_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (beat_words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word at %0t: tdata %h tuser %b",
						$realtime, m_axis_tdata, m_axis_tuser);
			end else begin
				want = beat_words_due.pop_front();
				if (m_axis_tuser !== want.beat
						|| m_axis_tdata[ecgrpd_pkg::RATE_BITS-1:0] !== want.rate
						|| m_axis_tdata[ecgrpd_pkg::RATE_BITS +: ecgrpd_pkg::SAMPLE_BITS]
							!== want.slope) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: beat %b/%b rate %0d/%0d slope %0d/%0d",
							$realtime, want.beat, m_axis_tuser,
							want.rate, m_axis_tdata[ecgrpd_pkg::RATE_BITS-1:0],
							want.slope,
							m_axis_tdata[ecgrpd_pkg::RATE_BITS +: ecgrpd_pkg::SAMPLE_BITS]);
				end
			end
		end
	end

	// long sink hold-off so the detector backs up into its input
	initial begin
		while (accepted < 60)
			@(posedge clk);
		sink_hold = 1'b1;
		repeat (300) @(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// wait until the detector has nothing in flight
	task automatic drain();
		while (ecg_samples.size() != 0 || beat_words_due.size() != 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [ecgrpd_pkg::CFG_ADDR_W-1:0] a,
		input logic [ecgrpd_pkg::CFG_BITS-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		apply_reg(a, d);
	endtask

	task automatic regs_done();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_defaults();
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT,
			ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_REFR_LIMIT));
		set_reg(ecgrpd_pkg::REG_TIMEOUT, ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_TIMEOUT));
		set_reg(ecgrpd_pkg::REG_IVAL_MIN, ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_IVAL_MIN));
		set_reg(ecgrpd_pkg::REG_IVAL_MAX, ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_IVAL_MAX));
		set_reg(ecgrpd_pkg::REG_RATE_NUM, ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_RATE_NUM));
		set_reg(ecgrpd_pkg::REG_TICK_STEP,
			ecgrpd_pkg::CFG_BITS'(ecgrpd_pkg::RST_TICK_STEP));
		regs_done();
	endtask

	// synthetic ecg: baseline with noise, a sharp r wave per period, stray artifacts
	task automatic push_ecg(input int n, input int plo, input int phi);
		int base, amp, period, k, v, left;
		left = n;
		base = $urandom_range(300, 2500);
		while (left > 0) begin
			amp = $urandom_range(150, 1600);
			period = $urandom_range(plo, phi);
			for (k = 0; k < period && left > 0; k++) begin
				v = base + $urandom_range(0, 12);
				if (k == period / 2)
					v += amp;
				else if (k == period / 2 - 1 || k == period / 2 + 1)
					v += amp / 3;
				if ($urandom_range(0, 39) == 0)
					v = $urandom_range(0, 4095);
				if (v > 4095)
					v = 4095;
				ecg_samples.push_back(ecgrpd_pkg::SAMPLE_BITS'(v));
				left--;
			end
		end
	endtask

	task automatic push_noise(input int n);
		for (int i = 0; i < n; i++)
			ecg_samples.push_back(ecgrpd_pkg::SAMPLE_BITS'($urandom_range(0, 4095)));
	endtask

	initial begin
		logic [ecgrpd_pkg::SAMPLE_BITS-1:0] directed [25];
		directed = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2048,
			12'd1, 12'd4094, 12'hAAA, 12'h555, 12'd4095, 12'd4095, 12'd4095,
			12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd100, 12'd3000, 12'd7,
			12'd4088, 12'd2047, 12'd2048};

		// model state after reset
		refr_limit = ecgrpd_pkg::RST_REFR_LIMIT;
		timeout_lim = ecgrpd_pkg::RST_TIMEOUT;
		ival_min = ecgrpd_pkg::RST_IVAL_MIN;
		ival_max = ecgrpd_pkg::RST_IVAL_MAX;
		rate_num = ecgrpd_pkg::RST_RATE_NUM;
		tick_step = ecgrpd_pkg::RST_TICK_STEP;
		for (int i = 0; i < ecgrpd_pkg::SLOPE_LAG; i++)
			win[i] = '0;
		slope_max = '0;
		slope_max_prev = '0;
		thresh = '0;
		armed = 1'b0;
		refr_cnt = '0;
		ival_cnt = '0;
		last_ival = '0;
		rate_hold = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed extremes at reset settings, first slopes against an empty window
		foreach (directed[i])
			ecg_samples.push_back(directed[i]);
		push_ecg(100, 40, 130);
		drain();

		// rearm on the first refractory step, wide range, largest numerator
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT, 16'd0);
		set_reg(ecgrpd_pkg::REG_TICK_STEP, 16'd1);
		set_reg(ecgrpd_pkg::REG_IVAL_MIN, 16'd0);
		set_reg(ecgrpd_pkg::REG_IVAL_MAX, 16'hFFFF);
		set_reg(ecgrpd_pkg::REG_RATE_NUM, 16'hFFFF);
		set_reg(ecgrpd_pkg::REG_TIMEOUT, 16'd32767);
		regs_done();
		push_ecg(80, 40, 130);
		drain();

		// timeout on every step
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT, 16'd60);
		set_reg(ecgrpd_pkg::REG_TIMEOUT, 16'd1);
		set_reg(ecgrpd_pkg::REG_TICK_STEP, 16'd255);
		regs_done();
		push_noise(40);
		drain();

		// longest refractory, the count runs up to the top of its register
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT, 16'd255);
		set_reg(ecgrpd_pkg::REG_TIMEOUT, 16'hFFFF);
		set_reg(ecgrpd_pkg::REG_TICK_STEP, 16'd1);
		regs_done();
		push_noise(30);
		push_ecg(240, 200, 280);
		drain();

		// catch a beat, then cut the limit while still refractory
		push_ecg(100, 50, 70);
		drain();
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT, 16'd1);
		regs_done();
		push_ecg(60, 20, 40);
		drain();

		// empty rate range holds the rate, spare indexes change nothing
		set_reg(ecgrpd_pkg::REG_REFR_LIMIT, 16'd20);
		set_reg(ecgrpd_pkg::REG_IVAL_MIN, 16'd500);
		set_reg(ecgrpd_pkg::REG_IVAL_MAX, 16'd501);
		set_reg(REG_SPARE_LO, 16'hFFFF);
		set_reg(REG_SPARE_HI, 16'hFFFF);
		set_reg(ecgrpd_pkg::REG_TICK_STEP, 16'd8);
		regs_done();
		push_ecg(40, 30, 80);
		drain();
		set_reg(ecgrpd_pkg::REG_IVAL_MIN, 16'hFFFF);
		set_reg(ecgrpd_pkg::REG_IVAL_MAX, 16'd0);
		set_reg(ecgrpd_pkg::REG_RATE_NUM, 16'd1);
		regs_done();
		push_ecg(20, 30, 80);
		drain();

		// random settings
		for (int p = 0; p < 2; p++) begin
			set_reg(ecgrpd_pkg::REG_REFR_LIMIT,
				ecgrpd_pkg::CFG_BITS'($urandom_range(0, 80)));
			set_reg(ecgrpd_pkg::REG_TIMEOUT,
				ecgrpd_pkg::CFG_BITS'($urandom_range(200, 32767)));
			set_reg(ecgrpd_pkg::REG_IVAL_MIN,
				ecgrpd_pkg::CFG_BITS'($urandom_range(0, 150)));
			set_reg(ecgrpd_pkg::REG_IVAL_MAX,
				ecgrpd_pkg::CFG_BITS'($urandom_range(150, 2000)));
			set_reg(ecgrpd_pkg::REG_RATE_NUM,
				ecgrpd_pkg::CFG_BITS'($urandom_range(1, 65535)));
			set_reg(ecgrpd_pkg::REG_TICK_STEP,
				ecgrpd_pkg::CFG_BITS'($urandom_range(1, 12)));
			regs_done();
			push_ecg(40, 30, 120);
			push_noise(10);
			drain();
		end

		// back to reset settings, no idling to the end
		write_defaults();
		no_idle = 1'b1;
		push_ecg(100, 60, 110);
		drain();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && beat_words_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
